[rtl/irt_pkg.sv]
package irt_pkg;

   localparam logic [1:0] KIND_CMD_CHAR   = 2'd0;
   localparam logic [1:0] KIND_PARAM_CHAR = 2'd1;
   localparam logic [1:0] KIND_TOKEN_END  = 2'd2;
   localparam logic [1:0] KIND_MSG_END    = 2'd3;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   localparam int unsigned RESULT_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_out;
      logic [3:0] token_index;
      logic       last;
   } result_type;

   // Up to two results per input byte, in order.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } result_pair_type;

endpackage

[rtl/irt_parser.sv]
module irt_parser #(
   parameter int unsigned MAX_PARAMS = 15
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               char_in,
   output irt_pkg::result_pair_type results
);

   localparam int unsigned CountWidth = $clog2(MAX_PARAMS + 1);

   typedef enum logic [2:0] {
      MODE_CMD,
      MODE_SEP,
      MODE_PARAM,
      MODE_TRAIL,
      MODE_SKIP
   } mode_type;

   mode_type              mode_ff, mode_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [CountWidth-1:0] count_bumped;
   logic                  is_cr, is_space, is_comma, is_colon;
   logic [3:0]            index_now, index_bumped;

   assign is_cr    = (char_in == irt_pkg::CHAR_CR);
   assign is_space = (char_in == irt_pkg::CHAR_SPACE);
   assign is_comma = (char_in == irt_pkg::CHAR_COMMA);
   assign is_colon = (char_in == irt_pkg::CHAR_COLON);

   // The parameter index holds at MAX_PARAMS once it gets there.
   assign count_bumped = (count_ff < CountWidth'(MAX_PARAMS)) ?
                         count_ff + CountWidth'(1) : count_ff;
   assign index_now    = 4'(count_ff);
   assign index_bumped = 4'(count_bumped);

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      results  = '0;
      unique case (mode_ff)
         MODE_CMD: begin
            if (is_cr) begin
               results.count        = 2'd2;
               results.first.kind   = irt_pkg::KIND_TOKEN_END;
               results.second.kind  = irt_pkg::KIND_MSG_END;
               mode_in              = MODE_SKIP;
            end else if (is_space) begin
               results.count      = 2'd1;
               results.first.kind = irt_pkg::KIND_TOKEN_END;
               mode_in            = MODE_SEP;
            end else begin
               results.count          = 2'd1;
               results.first.kind     = irt_pkg::KIND_CMD_CHAR;
               results.first.char_out = char_in;
            end
         end
         MODE_SEP: begin
            if (is_cr) begin
               results.count      = 2'd1;
               results.first.kind = irt_pkg::KIND_MSG_END;
               mode_in            = MODE_SKIP;
            end else if (is_space || is_comma) begin
               results.count = 2'd0;
            end else if (is_colon) begin
               count_in = count_bumped;
               mode_in  = MODE_TRAIL;
            end else begin
               count_in                  = count_bumped;
               results.count             = 2'd1;
               results.first.kind        = irt_pkg::KIND_PARAM_CHAR;
               results.first.char_out    = char_in;
               results.first.token_index = index_bumped;
               mode_in                   = MODE_PARAM;
            end
         end
         MODE_PARAM, MODE_TRAIL: begin
            if (is_cr) begin
               results.count             = 2'd2;
               results.first.kind        = irt_pkg::KIND_TOKEN_END;
               results.first.token_index = index_now;
               results.second.kind       = irt_pkg::KIND_MSG_END;
               mode_in                   = MODE_SKIP;
            end else if (is_comma || (is_space && (mode_ff == MODE_PARAM))) begin
               results.count             = 2'd1;
               results.first.kind        = irt_pkg::KIND_TOKEN_END;
               results.first.token_index = index_now;
               mode_in                   = MODE_SEP;
            end else begin
               results.count             = 2'd1;
               results.first.kind        = irt_pkg::KIND_PARAM_CHAR;
               results.first.char_out    = char_in;
               results.first.token_index = index_now;
            end
         end
         MODE_SKIP: begin
            count_in = '0;
            mode_in  = MODE_CMD;
         end
         default: begin
            count_in = '0;
            mode_in  = MODE_CMD;
         end
      endcase
      // The last flag marks whichever result closes this byte.
      if (results.count == 2'd2) begin
         results.second.last = 1'b1;
      end else if (results.count == 2'd1) begin
         results.first.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_CMD;
         count_ff <= '0;
      end else if (step) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

endmodule

[rtl/irt_rsp_queue.sv]
module irt_rsp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  irt_pkg::result_pair_type push_data,
   output logic                     room,
   output logic                     out_valid,
   input  logic                     out_stall,
   output irt_pkg::result_type      out_data
);

   localparam int unsigned Depth     = irt_pkg::RESULT_QUEUE_DEPTH;
   localparam int unsigned PtrWidth  = $clog2(Depth);
   localparam int unsigned FillWidth = $clog2(Depth + 1);

   irt_pkg::result_type  entry_ff [Depth];
   logic [PtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FillWidth-1:0] fill_ff, fill_in;
   logic [PtrWidth-1:0]  wr_ptr_next;
   logic [1:0]           push_count;
   logic                 pop;

   // Room is judged on the registered fill alone, so it never waits on out_stall.
   assign room        = (fill_ff <= FillWidth'(Depth - 2));
   assign out_valid   = (fill_ff != '0);
   assign out_data    = entry_ff[rd_ptr_ff];
   assign pop         = out_valid && !out_stall;
   assign push_count  = push ? push_data.count : 2'd0;
   assign wr_ptr_next = wr_ptr_ff + PtrWidth'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrWidth'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + PtrWidth'(1) : rd_ptr_ff;
      fill_in   = fill_ff + FillWidth'(push_count) - FillWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_data.first;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push_data.second;
      end
   end

endmodule

[rtl/irc_line_tokenizer.sv]
// Byte-serial line tokenizer. One message byte is taken per beat on the req_
// channel and each CR-terminated line comes out on the rsp_ channel as command
// characters, parameter characters, token-end beats carrying the token index and
// a message-end beat; rsp_last marks the final beat caused by a byte. A byte
// gives zero, one or two result beats, so the block takes one byte per clock as
// long as bytes average no more than one result beat each and rsp_stall stays
// low. A byte is held in the input register, where the parser decides its
// results and its next state, and the results then wait in a four-entry result
// queue; the first result is offered on rsp_ once it has passed through both.
// While the queue holds more than two beats the input register keeps its byte
// and the req_ side stalls. The parameter index saturates at MAX_PARAMS.
// A final line without CR still gives its tokens but no message end.
module irc_line_tokenizer #(
   parameter int unsigned MAX_PARAMS = 15
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_char_out,
   output logic [3:0] rsp_token_index,
   output logic       rsp_last
);

   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               in_char_ff, in_char_in;
   logic                     room;
   logic                     advance;
   logic                     accept;
   irt_pkg::result_pair_type results;
   irt_pkg::result_type      head;

   assign advance   = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign in_char_in  = accept ? req_char_in : in_char_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_char_ff <= in_char_in;
   end

   irt_parser #(
      .MAX_PARAMS(MAX_PARAMS)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .char_in (in_char_ff),
      .results (results)
   );

   irt_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .push_data (results),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (head)
   );

   assign rsp_kind        = head.kind;
   assign rsp_char_out    = head.char_out;
   assign rsp_token_index = head.token_index;
   assign rsp_last        = head.last;

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result queue or input register not empty after reset");

   a_msg_end_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == irt_pkg::KIND_MSG_END) |->
         (rsp_token_index == 4'd0) && (rsp_char_out == 8'd0) && rsp_last)
      else $error("message end beat carries stray fields");

   a_cmd_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == irt_pkg::KIND_CMD_CHAR) |->
         (rsp_token_index == 4'd0) && rsp_last)
      else $error("command character with nonzero index or not last");

   a_held_byte_stalls: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !room |=> in_valid_ff && $stable(in_char_ff))
      else $error("held input byte lost while queue was full");

endmodule

[tb/sv/tb_irc_line_tokenizer.sv]
`timescale 1ns / 100ps

module tb_irc_line_tokenizer;

   localparam int unsigned MAX_PARAMS = 15;
   localparam int unsigned BYTES_PER_PHASE = 185;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 16;

   typedef enum logic [2:0] {
      LINE_COMMAND,
      LINE_SEPARATOR,
      LINE_PARAMETER,
      LINE_TRAILING,
      LINE_SKIP
   } line_state_type;

   // Tracks the line parser and holds the token beats still owed by the block.
   class token_scoreboard;
      line_state_type state;
      logic [3:0] param_index;
      irt_pkg::result_type pending[$];
      int unsigned errors;
      int unsigned checked;
      int unsigned lines_ended;
      int unsigned deepest_index;

      function new();
         state = LINE_COMMAND;
         param_index = '0;
      endfunction

      function void bump_param();
         if (param_index < MAX_PARAMS) param_index++;
         if (param_index > deepest_index) deepest_index = param_index;
      endfunction

      function void note_byte(logic [7:0] c);
         irt_pkg::result_type batch [2];
         irt_pkg::result_type r;
         int n;
         r = '0;
         n = 0;
         batch[0] = '0;
         batch[1] = '0;
         case (state)
            LINE_COMMAND: begin
               if (c == irt_pkg::CHAR_CR) begin
                  r.kind = irt_pkg::KIND_TOKEN_END; batch[n] = r; n++;
                  r.kind = irt_pkg::KIND_MSG_END;   batch[n] = r; n++;
                  state = LINE_SKIP;
               end else if (c == irt_pkg::CHAR_SPACE) begin
                  r.kind = irt_pkg::KIND_TOKEN_END; batch[n] = r; n++;
                  state = LINE_SEPARATOR;
               end else begin
                  r.kind = irt_pkg::KIND_CMD_CHAR; r.char_out = c;
                  batch[n] = r; n++;
               end
            end
            LINE_SEPARATOR: begin
               if (c == irt_pkg::CHAR_CR) begin
                  r.kind = irt_pkg::KIND_MSG_END; batch[n] = r; n++;
                  state = LINE_SKIP;
               end else if (c == irt_pkg::CHAR_COLON) begin
                  bump_param();
                  state = LINE_TRAILING;
               end else if (c != irt_pkg::CHAR_SPACE && c != irt_pkg::CHAR_COMMA) begin
                  bump_param();
                  r.kind = irt_pkg::KIND_PARAM_CHAR;
                  r.char_out = c;
                  r.token_index = param_index;
                  batch[n] = r; n++;
                  state = LINE_PARAMETER;
               end
            end
            LINE_PARAMETER, LINE_TRAILING: begin
               // A trailing parameter keeps spaces; only comma or CR close it.
               if (c == irt_pkg::CHAR_CR) begin
                  r.kind = irt_pkg::KIND_TOKEN_END; r.token_index = param_index;
                  batch[n] = r; n++;
                  r = '0; r.kind = irt_pkg::KIND_MSG_END; batch[n] = r; n++;
                  state = LINE_SKIP;
               end else if (c == irt_pkg::CHAR_COMMA ||
                            (c == irt_pkg::CHAR_SPACE && state == LINE_PARAMETER)) begin
                  r.kind = irt_pkg::KIND_TOKEN_END; r.token_index = param_index;
                  batch[n] = r; n++;
                  state = LINE_SEPARATOR;
               end else begin
                  r.kind = irt_pkg::KIND_PARAM_CHAR;
                  r.char_out = c;
                  r.token_index = param_index;
                  batch[n] = r; n++;
               end
            end
            default: begin
               state = LINE_COMMAND;
               param_index = '0;
            end
         endcase
         if (n > 0) batch[n - 1].last = 1'b1;
         for (int i = 0; i < n; i++) begin
            if (batch[i].kind == irt_pkg::KIND_MSG_END) lines_ended++;
            pending = {pending, batch[i]};
         end
      endfunction

      function void check_result(irt_pkg::result_type got);
         irt_pkg::result_type want;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat kind %0d char %02h index %0d last %0b",
                     $time, got.kind, got.char_out, got.token_index, got.last);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.kind !== want.kind) begin
            $display("%0t: rsp_kind expected %0d got %0d", $time, want.kind, got.kind);
            errors++;
         end
         if (got.char_out !== want.char_out) begin
            $display("%0t: rsp_char_out expected %02h got %02h", $time, want.char_out,
                     got.char_out);
            errors++;
         end
         if (got.token_index !== want.token_index) begin
            $display("%0t: rsp_token_index expected %0d got %0d", $time, want.token_index,
                     got.token_index);
            errors++;
         end
         if (got.last !== want.last) begin
            $display("%0t: rsp_last expected %0b got %0b", $time, want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_char_in;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_char_out;
   logic [3:0] rsp_token_index;
   logic       rsp_last;

   token_scoreboard tokens = new();
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned bytes_sent = 0;
   int unsigned cycle_count = 0;

   irc_line_tokenizer #(.MAX_PARAMS(MAX_PARAMS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_in(req_char_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_char_out(rsp_char_out),
      .rsp_token_index(rsp_token_index),
      .rsp_last(rsp_last)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tokens.check_result('{rsp_kind, rsp_char_out, rsp_token_index, rsp_last});
   end

   // Valid is lowered only by an idle wait in the next call or by the caller, so back-to-back beats keep it high.
   task automatic send_byte(input logic [7:0] c);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_char_in = c;
      do @(posedge clock); while (req_stall);
      tokens.note_byte(c);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == irt_pkg::CHAR_CR || c == irt_pkg::CHAR_SPACE ||
             c == irt_pkg::CHAR_COMMA || c == irt_pkg::CHAR_COLON);
      return c;
   endfunction

   function automatic logic [7:0] special_char();
      case ($urandom_range(0, 3))
         0: return irt_pkg::CHAR_CR;
         1: return irt_pkg::CHAR_SPACE;
         2: return irt_pkg::CHAR_COMMA;
         default: return irt_pkg::CHAR_COLON;
      endcase
   endfunction

   // One message line with random content; a broken line simply stops early.
   task automatic send_line(input bit terminate);
      int unsigned cmd_len;
      int unsigned param_total;
      bit after_trailing;
      cmd_len = $urandom_range(0, 5);
      param_total = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18)
                                                : $urandom_range(0, 4);
      after_trailing = 1'b0;
      for (int i = 0; i < cmd_len; i++)
         send_byte(($urandom_range(0, 7) == 0) ?
                   ($urandom_range(0, 1) ? irt_pkg::CHAR_COMMA : irt_pkg::CHAR_COLON)
                   : plain_char());
      if (param_total == 0 && $urandom_range(0, 1)) send_byte(irt_pkg::CHAR_SPACE);
      for (int p = 0; p < param_total; p++) begin
         if (p == 0) send_byte(irt_pkg::CHAR_SPACE);
         else if (after_trailing) send_byte(irt_pkg::CHAR_COMMA);
         else send_byte($urandom_range(0, 1) ? irt_pkg::CHAR_SPACE : irt_pkg::CHAR_COMMA);
         if ($urandom_range(0, 3) == 0)
            send_byte($urandom_range(0, 1) ? irt_pkg::CHAR_SPACE : irt_pkg::CHAR_COMMA);
         after_trailing = ($urandom_range(0, 4) == 0) ||
                          (p == param_total - 1 && $urandom_range(0, 2) == 0);
         if (after_trailing) begin
            send_byte(irt_pkg::CHAR_COLON);
            repeat ($urandom_range(0, 5)) begin
               case ($urandom_range(0, 3))
                  0: send_byte(irt_pkg::CHAR_SPACE);
                  1: send_byte(irt_pkg::CHAR_COLON);
                  default: send_byte(plain_char());
               endcase
            end
         end else begin
            send_byte(plain_char());
            repeat ($urandom_range(0, 3))
               send_byte(($urandom_range(0, 5) == 0) ? irt_pkg::CHAR_COLON : plain_char());
         end
      end
      if (terminate) begin
         send_byte(irt_pkg::CHAR_CR);
         send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 8))
         send_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : special_char());
   endtask

   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_chance);
      int unsigned target;
      send_idle_pct = idle_pct;
      stall_pct = stall_chance;
      target = bytes_sent + BYTES_PER_PHASE;
      while (bytes_sent < target) begin
         case ($urandom_range(0, 9))
            0: send_noise();
            1: send_line(1'b0);
            default: send_line(1'b1);
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_char_in = '0;
      rsp_stall = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      fork
         begin
            // Empty command closed by CR, then a zero byte that gets skipped.
            send_byte(irt_pkg::CHAR_CR);
            send_byte(8'h00);
            // Empty command before a space, then an empty trailing parameter.
            send_byte(irt_pkg::CHAR_SPACE);
            send_byte(irt_pkg::CHAR_COLON);
            send_byte(irt_pkg::CHAR_CR);
            send_byte(8'hFF);
            // Comma, zero and 0xFF inside the command; colon inside a parameter;
            // a trailing parameter with a space that is closed by a comma.
            send_text("A,");
            send_byte(8'h00);
            send_byte(8'hFF);
            send_text(" b:c,:d e,f");
            send_byte(irt_pkg::CHAR_CR);
            send_byte(8'h0A);

            run_phase(0, 0);
            run_phase(47, 0);
            run_phase(0, 47);
            run_phase(31, 31);
            send_line(1'b0);
            @(negedge clock);
            req_valid = 1'b0;

            while (tokens.pending.size() != 0) @(posedge clock);
            repeat (DRAIN_CYCLES) @(posedge clock);
         end
         begin
            while (cycle_count < CYCLE_LIMIT) @(posedge clock);
         end
      join_any

      if (cycle_count >= CYCLE_LIMIT)
         $display("%0t: timed out after %0d cycles", $time, cycle_count);
      if (tokens.pending.size() != 0)
         $display("%0t: %0d expected result beats never arrived", $time,
                  tokens.pending.size());
      $display("Sent %0d bytes over four idle/stall mixes; checked %0d result beats, %0d lines.",
               bytes_sent, tokens.checked, tokens.lines_ended);
      $display("Highest parameter index reached: %0d (saturates at %0d).",
               tokens.deepest_index, MAX_PARAMS);
      if (cycle_count < CYCLE_LIMIT && tokens.errors == 0 && tokens.pending.size() == 0) begin
         $display("irc_line_tokenizer test passed");
      end else begin
         $display("irc_line_tokenizer test failed");
      end
      $finish;
   end

endmodule

[irc_line_tokenizer.f]
rtl/irt_pkg.sv
rtl/irt_parser.sv
rtl/irt_rsp_queue.sv
rtl/irc_line_tokenizer.sv
tb/sv/tb_irc_line_tokenizer.sv
